// ===== design/lzrle_pkg.sv =====
// shared types and constants for the lz77/rle token decompressor
package lzrle_pkg;

  localparam int HIST_DEPTH = 4096;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);
  localparam int OUT_LANES  = 4;
  localparam int LANE_CW    = $clog2(OUT_LANES + 1);
  localparam int LANE_IW    = $clog2(OUT_LANES);

  localparam logic [15:0] LIMIT_RESET = 16'd38400;

  // opcode in the two low bits of a nonzero header
  localparam logic [1:0] OP_LIT   = 2'd0;
  localparam logic [1:0] OP_SHORT = 2'd1;
  localparam logic [1:0] OP_MID   = 2'd2;
  localparam logic [1:0] OP_LONG  = 2'd3;

  typedef enum logic [2:0] {
    PH_HDR, PH_RCNT, PH_RVAL, PH_B1, PH_B2, PH_LIT
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EXEC, ST_RUN, ST_COPY, ST_POST
  } ctl_state_t;

  typedef enum logic [1:0] {
    TR_CONT, TR_DONE, TR_STOP, TR_LIMIT
  } tok_res_t;

  typedef enum logic [1:0] {
    ES_RUNNING, ES_STOP, ES_LIMIT, ES_INPUT
  } end_status_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       stream_first;
    logic       stream_last;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]  out_byte0;
    logic [7:0]  out_byte1;
    logic [7:0]  out_byte2;
    logic [7:0]  out_byte3;
    logic [2:0]  byte_count;
    logic        run_last;
    logic        finished;
    logic [1:0]  end_status;
    logic [15:0] consumed_count;
    logic        used_matches;
  } out_beat_t;

endpackage

// ===== design/lz77_rle_token_decompressor_core.sv =====
// lz77/rle token decompressor core with a 4096-byte history ring
//
// Compressed bytes enter on in_valid/in_ready, one per beat, with
// stream_first (clears history and counters) and stream_last marks.
// Decoded bytes leave on out_valid/out_ready packed up to four per beat;
// the last beat caused by an input byte has run_last set, and the beat that
// ends a stream carries finished, end_status and the consumed byte count.
// cfg_valid/cfg_ready writes output_limit; cfg_ready is always high. Writes
// are to be made while the block is idle; the block itself does not enforce it.
// Steps: a header, count or literal byte goes through accept, decode and step end.
// A run or a match then passes through the run or copy state before step end;
// the ring's single read port issues one byte a cycle unless the output stalls,
// with the byte written just before forwarded when the copy overlaps it.
// Each padded byte after stream_last goes through decode and step end.
// The history ring needs no clearing pass: a fill mark (write pointer plus
// a wrapped flag) makes never-written entries read as zero.
// Reset puts the block idle with an open stream and output_limit 38400.
// While the receiver stalls with a full output register, decoding holds
// and input is not taken until the current byte's work is done.
module lz77_rle_token_decompressor_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  lzrle_pkg::in_beat_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output lzrle_pkg::out_beat_t out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [15:0]          cfg_data
);

  localparam int AW = lzrle_pkg::HIST_AW;
  localparam int CW = lzrle_pkg::LANE_CW;
  localparam int IW = lzrle_pkg::LANE_IW;
  localparam int NL = lzrle_pkg::OUT_LANES;

  // control and token registers
  lzrle_pkg::ctl_state_t state, state_next;
  lzrle_pkg::phase_t     phase, phase_next;
  lzrle_pkg::tok_res_t   res, res_next;
  logic [7:0]  header_byte, header_byte_next;
  logic [7:0]  second_byte, second_byte_next;
  logic [5:0]  lit_left, lit_left_next;
  logic [5:0]  pend_len, pend_len_next;
  logic [AW-1:0] pend_dist, pend_dist_next;
  logic [7:0]  run_cnt, run_cnt_next;
  logic [7:0]  run_val, run_val_next;
  logic [5:0]  icnt, icnt_next;
  logic [AW-1:0] src, src_next;
  logic        rd_pend, rd_pend_next;
  logic [7:0]  cur_byte, cur_byte_next;
  logic        last_q, last_q_next;
  logic        pad, pad_next;
  logic [AW-1:0] wp, wp_next;
  logic        filled, filled_next;
  logic [16:0] bw, bw_next;
  logic [15:0] consumed, consumed_next;
  logic        match_seen, match_seen_next;
  logic        done, done_next;
  logic [15:0] output_limit;
  logic [CW-1:0] lanes, lanes_next;
  logic [7:0]  lane_buf [NL];

  // ring memory and read side
  logic [7:0]  ring [lzrle_pkg::HIST_DEPTH];
  logic [7:0]  rd_data;
  logic        rd_en;
  logic        rd_valid;
  logic        fwd_hit;
  logic [7:0]  fwd_data;
  logic [7:0]  copy_data;

  // byte put and beat emission
  logic        put_req, put_en, stall, lane_full, out_free;
  logic [7:0]  put_data;
  logic        exec_skip, exec_limit, exec_go;
  logic        emit_en, emit_fin;
  logic [1:0]  emit_status;
  lzrle_pkg::out_beat_t emit_beat;

  assign in_ready  = (state == lzrle_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;
  assign lane_full = (lanes == CW'(NL));

  assign exec_skip  = !pad && done;
  assign exec_limit = !pad && (phase == lzrle_pkg::PH_HDR) && (bw >= {1'b0, output_limit});
  assign exec_go    = !exec_skip && !exec_limit;

  assign copy_data = fwd_hit ? fwd_data : (rd_valid ? rd_data : 8'd0);

  // which byte goes into the ring this cycle
  always_comb begin
    put_req  = 1'b0;
    put_data = cur_byte;
    case (state)
      lzrle_pkg::ST_EXEC: put_req = exec_go && (phase == lzrle_pkg::PH_LIT);
      lzrle_pkg::ST_RUN: begin
        put_req  = (run_cnt != 8'd0);
        put_data = run_val;
      end
      lzrle_pkg::ST_COPY: begin
        put_req  = rd_pend;
        put_data = copy_data;
      end
      default: put_req = 1'b0;
    endcase
  end

  assign stall  = put_req && lane_full && !out_free;
  assign put_en = put_req && !stall;
  assign rd_en  = (state == lzrle_pkg::ST_COPY) && (icnt != 6'd0) && !stall;

  // beat built from the lane buffer, unused lanes zero
  always_comb begin
    emit_beat = '0;
    emit_beat.out_byte0 = (lanes > CW'(0)) ? lane_buf[0] : 8'd0;
    emit_beat.out_byte1 = (lanes > CW'(1)) ? lane_buf[1] : 8'd0;
    emit_beat.out_byte2 = (lanes > CW'(2)) ? lane_buf[2] : 8'd0;
    emit_beat.out_byte3 = (lanes > CW'(3)) ? lane_buf[3] : 8'd0;
    emit_beat.byte_count     = 3'(lanes);
    emit_beat.run_last       = !put_en;
    emit_beat.finished       = emit_fin;
    emit_beat.end_status     = emit_fin ? emit_status : lzrle_pkg::ES_RUNNING;
    emit_beat.consumed_count = emit_fin ? consumed : 16'd0;
    emit_beat.used_matches   = match_seen;
  end

  // next state and decode
  always_comb begin
    state_next       = state;
    phase_next       = phase;
    res_next         = res;
    header_byte_next = header_byte;
    second_byte_next = second_byte;
    lit_left_next    = lit_left;
    pend_len_next    = pend_len;
    pend_dist_next   = pend_dist;
    run_cnt_next     = run_cnt;
    run_val_next     = run_val;
    icnt_next        = icnt;
    src_next         = src;
    rd_pend_next     = rd_pend;
    cur_byte_next    = cur_byte;
    last_q_next      = last_q;
    pad_next         = pad;
    wp_next          = wp;
    filled_next      = filled;
    bw_next          = bw;
    consumed_next    = consumed;
    match_seen_next  = match_seen;
    done_next        = done;
    lanes_next       = lanes;
    emit_en          = 1'b0;
    emit_fin         = 1'b0;
    emit_status      = lzrle_pkg::ES_RUNNING;

    // effects of a put
    if (put_en) begin
      wp_next = wp + AW'(1);
      if (wp == AW'(lzrle_pkg::HIST_DEPTH - 1)) filled_next = 1'b1;
      if (bw != 17'h1FFFF) bw_next = bw + 17'd1;
      if (lane_full) begin
        emit_en    = 1'b1;
        lanes_next = CW'(1);
      end else begin
        lanes_next = lanes + CW'(1);
      end
    end

    case (state)
      lzrle_pkg::ST_IDLE: begin
        if (in_valid) begin
          cur_byte_next = in_data.in_byte;
          last_q_next   = in_data.stream_last;
          pad_next      = 1'b0;
          state_next    = lzrle_pkg::ST_EXEC;
          if (in_data.stream_first) begin
            wp_next          = '0;
            filled_next      = 1'b0;
            phase_next       = lzrle_pkg::PH_HDR;
            header_byte_next = 8'd0;
            second_byte_next = 8'd0;
            lit_left_next    = 6'd0;
            pend_len_next    = 6'd0;
            pend_dist_next   = '0;
            bw_next          = 17'd0;
            consumed_next    = 16'd0;
            match_seen_next  = 1'b0;
            done_next        = 1'b0;
          end
        end
      end

      lzrle_pkg::ST_EXEC: begin
        if (!stall) begin
          if (exec_skip) begin
            state_next = lzrle_pkg::ST_IDLE;
          end else if (exec_limit) begin
            res_next   = lzrle_pkg::TR_LIMIT;
            state_next = lzrle_pkg::ST_POST;
          end else begin
            logic after, go_match;
            after    = 1'b0;
            go_match = 1'b0;
            if (consumed != 16'hFFFF) consumed_next = consumed + 16'd1;
            state_next = lzrle_pkg::ST_POST;
            res_next   = lzrle_pkg::TR_CONT;
            case (phase)
              lzrle_pkg::PH_HDR: begin
                header_byte_next = cur_byte;
                if (cur_byte == 8'd0) begin
                  phase_next = lzrle_pkg::PH_RCNT;
                end else if (cur_byte[1:0] != lzrle_pkg::OP_LIT) begin
                  match_seen_next = 1'b1;
                  phase_next      = lzrle_pkg::PH_B1;
                end else begin
                  lit_left_next  = cur_byte[7:2];
                  pend_len_next  = 6'd0;
                  pend_dist_next = '0;
                  after          = 1'b1;
                end
              end
              lzrle_pkg::PH_RCNT: begin
                if (cur_byte == 8'd0) begin
                  phase_next = lzrle_pkg::PH_HDR;
                  res_next   = lzrle_pkg::TR_STOP;
                end else begin
                  second_byte_next = cur_byte;
                  phase_next       = lzrle_pkg::PH_RVAL;
                end
              end
              lzrle_pkg::PH_RVAL: begin
                run_cnt_next = second_byte;
                run_val_next = cur_byte;
                phase_next   = lzrle_pkg::PH_HDR;
                res_next     = lzrle_pkg::TR_DONE;
                state_next   = lzrle_pkg::ST_RUN;
              end
              lzrle_pkg::PH_B1: begin
                second_byte_next = cur_byte;
                case (header_byte[1:0])
                  lzrle_pkg::OP_SHORT: begin
                    lit_left_next  = {4'd0, header_byte[3:2]};
                    pend_len_next  = 6'd3 + {3'd0, header_byte[6:4]};
                    pend_dist_next = {3'd0, cur_byte, header_byte[7]};
                    after          = 1'b1;
                  end
                  lzrle_pkg::OP_MID: begin
                    lit_left_next  = 6'd0;
                    pend_len_next  = 6'd3 + {4'd0, header_byte[3:2]};
                    pend_dist_next = {cur_byte, header_byte[7:4]};
                    after          = 1'b1;
                  end
                  default: phase_next = lzrle_pkg::PH_B2;
                endcase
              end
              lzrle_pkg::PH_B2: begin
                lit_left_next  = {2'd0, header_byte[5:2]};
                pend_len_next  = {second_byte[3:0], header_byte[7:6]};
                pend_dist_next = {cur_byte, second_byte[7:4]};
                after          = 1'b1;
              end
              lzrle_pkg::PH_LIT: begin
                lit_left_next = (lit_left != 6'd0) ? lit_left - 6'd1 : 6'd0;
                if (lit_left_next == 6'd0) go_match = 1'b1;
              end
              default: begin
                phase_next = lzrle_pkg::PH_HDR;
                res_next   = lzrle_pkg::TR_DONE;
              end
            endcase
            // literals first, else straight to the match
            if (after) begin
              if (lit_left_next != 6'd0) phase_next = lzrle_pkg::PH_LIT;
              else go_match = 1'b1;
            end
            if (go_match) begin
              phase_next   = lzrle_pkg::PH_HDR;
              res_next     = lzrle_pkg::TR_DONE;
              state_next   = lzrle_pkg::ST_COPY;
              icnt_next    = pend_len_next;
              src_next     = wp_next - pend_dist_next;
              rd_pend_next = 1'b0;
            end
          end
        end
      end

      lzrle_pkg::ST_RUN: begin
        if (!stall) begin
          if (run_cnt != 8'd0) run_cnt_next = run_cnt - 8'd1;
          else state_next = lzrle_pkg::ST_POST;
        end
      end

      lzrle_pkg::ST_COPY: begin
        if (!stall) begin
          rd_pend_next = rd_en;
          if (rd_en) begin
            src_next  = src + AW'(1);
            icnt_next = icnt - 6'd1;
          end
          if (!rd_pend && (icnt == 6'd0)) state_next = lzrle_pkg::ST_POST;
        end
      end

      lzrle_pkg::ST_POST: begin
        // step end: finish, pad after the last byte, or flush lanes
        if ((res == lzrle_pkg::TR_LIMIT) || (res == lzrle_pkg::TR_STOP) ||
            (last_q && (res != lzrle_pkg::TR_CONT))) begin
          if (out_free) begin
            emit_en     = 1'b1;
            emit_fin    = 1'b1;
            case (res)
              lzrle_pkg::TR_LIMIT: emit_status = lzrle_pkg::ES_LIMIT;
              lzrle_pkg::TR_STOP:  emit_status = lzrle_pkg::ES_STOP;
              default:             emit_status = lzrle_pkg::ES_INPUT;
            endcase
            done_next   = 1'b1;
            lanes_next  = '0;
            state_next  = lzrle_pkg::ST_IDLE;
          end
        end else if (last_q) begin
          cur_byte_next = 8'd0;
          pad_next      = 1'b1;
          state_next    = lzrle_pkg::ST_EXEC;
        end else if (lanes != '0) begin
          if (out_free) begin
            emit_en    = 1'b1;
            lanes_next = '0;
            state_next = lzrle_pkg::ST_IDLE;
          end
        end else begin
          state_next = lzrle_pkg::ST_IDLE;
        end
      end

      default: state_next = lzrle_pkg::ST_IDLE;
    endcase
  end

  // history ring with registered read and same-entry forwarding
  always_ff @(posedge clk) begin
    if (put_en) ring[wp] <= put_data;
    if (rd_en) begin
      rd_data  <= ring[src];
      fwd_hit  <= put_en && (wp == src);
      fwd_data <= put_data;
      rd_valid <= filled || (src < wp);
    end
  end

  // lane buffer
  always_ff @(posedge clk) begin
    if (put_en) begin
      if (lane_full) lane_buf[0] <= put_data;
      else lane_buf[lanes[IW-1:0]] <= put_data;
    end
  end

  // token payload registers
  always_ff @(posedge clk) begin
    header_byte <= header_byte_next;
    second_byte <= second_byte_next;
    lit_left    <= lit_left_next;
    pend_len    <= pend_len_next;
    pend_dist   <= pend_dist_next;
    run_cnt     <= run_cnt_next;
    run_val     <= run_val_next;
    icnt        <= icnt_next;
    src         <= src_next;
    cur_byte    <= cur_byte_next;
    last_q      <= last_q_next;
    res         <= res_next;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= lzrle_pkg::ST_IDLE;
      phase        <= lzrle_pkg::PH_HDR;
      rd_pend      <= 1'b0;
      pad          <= 1'b0;
      wp           <= '0;
      filled       <= 1'b0;
      bw           <= 17'd0;
      consumed     <= 16'd0;
      match_seen   <= 1'b0;
      done         <= 1'b0;
      lanes        <= '0;
      out_valid    <= 1'b0;
      output_limit <= lzrle_pkg::LIMIT_RESET;
    end else begin
      state      <= state_next;
      phase      <= phase_next;
      rd_pend    <= rd_pend_next;
      pad        <= pad_next;
      wp         <= wp_next;
      filled     <= filled_next;
      bw         <= bw_next;
      consumed   <= consumed_next;
      match_seen <= match_seen_next;
      done       <= done_next;
      lanes      <= lanes_next;
      if (emit_en) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (cfg_valid) output_limit <= cfg_data;
    end
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (emit_en) out_data <= emit_beat;
  end

endmodule
